// ===== design/bc6h_pkg.sv =====
// Shared types, constants and helpers for the BC6H mode 11 block decoder.
// No dependencies; imported by the lane, merge and top-level modules.
package bc6h_pkg;

    localparam int unsigned NUM_TEXELS = 16;
    localparam int unsigned EP_BITS    = 10;
    localparam int unsigned UQ_BITS    = 16;
    localparam int unsigned W_BITS     = 7;
    localparam int unsigned HALF_BITS  = 15;
    localparam int unsigned TEXEL_BITS = 4;

    localparam logic [4:0]         MODE11_CODE = 5'b00011;
    localparam logic [EP_BITS-1:0] EP_MAX      = 10'd1023;
    localparam logic [UQ_BITS-1:0] UQ_MAX      = 16'hffff;

    typedef logic [UQ_BITS-1:0]    uq_t;
    typedef logic [HALF_BITS-1:0]  half_t;
    typedef logic [TEXEL_BITS-1:0] texel_t;

    // Control info that travels with one texel through the merge stage.
    typedef struct packed {
        texel_t texel;
        logic   err;
        logic   last;
    } meta_t;

    // Interpolation weight for a 4-bit index.
    function automatic logic [W_BITS-1:0] weight_of(input logic [3:0] idx);
        logic [W_BITS-1:0] w;
        case (idx)
            4'd0:    w = 7'd0;
            4'd1:    w = 7'd4;
            4'd2:    w = 7'd9;
            4'd3:    w = 7'd13;
            4'd4:    w = 7'd17;
            4'd5:    w = 7'd21;
            4'd6:    w = 7'd26;
            4'd7:    w = 7'd30;
            4'd8:    w = 7'd34;
            4'd9:    w = 7'd38;
            4'd10:   w = 7'd43;
            4'd11:   w = 7'd47;
            4'd12:   w = 7'd51;
            4'd13:   w = 7'd55;
            4'd14:   w = 7'd60;
            4'd15:   w = 7'd64;
            default: w = 7'd0;
        endcase
        return w;
    endfunction

    // 10-bit endpoint to 16 bits: (v << 16 + 0x8000) >> 10 is v*64 + 32.
    function automatic uq_t unquantize(input logic [EP_BITS-1:0] v);
        uq_t r;
        if (v == '0) begin
            r = '0;
        end else if (v == EP_MAX) begin
            r = UQ_MAX;
        end else begin
            r = {v, 6'b100000};
        end
        return r;
    endfunction

    // (x * 31) >> 6 as a shift and subtract.
    function automatic half_t finish_half(input uq_t x);
        logic [UQ_BITS+4:0] prod;
        prod = {x, 5'b00000} - {5'b00000, x};
        return prod[UQ_BITS+4:6];
    endfunction

endpackage

// ===== design/bc6h_lane.sv =====
// One channel lane: blends two unquantized endpoints by a 7-bit weight.
// Depends on bc6h_pkg; registers the blended 16-bit value per issued texel.
module bc6h_lane import bc6h_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  uq_t               e0,
    input  uq_t               e1,
    input  logic [W_BITS-1:0] w,
    output uq_t               x_reg
);

    logic [W_BITS-1:0] w_inv;
    logic [22:0]       p0;
    logic [22:0]       p1;
    logic [22:0]       sum;
    uq_t               x_next;

    always_comb begin
        w_inv  = 7'd64 - w;
        p0     = 23'(w_inv) * 23'(e0);
        p1     = 23'(w) * 23'(e1);
        sum    = p0 + p1 + 23'd32;
        x_next = sum[21:6];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg <= x_next;
        end
    end

endmodule

// ===== design/bc6h_merge.sv =====
// Merge stage: joins the three lane values with texel info, finishes FP16
// patterns and holds the output register. Depends on bc6h_pkg.
module bc6h_merge import bc6h_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   issue,
    input  meta_t  meta_in,
    output logic   issue_ready,
    input  uq_t    x_r,
    input  uq_t    x_g,
    input  uq_t    x_b,
    output logic   out_valid,
    input  logic   out_ready,
    output meta_t  out_meta,
    output half_t  out_r,
    output half_t  out_g,
    output half_t  out_b
);

    logic  s1_valid_reg;
    logic  s1_valid_next;
    meta_t s1_meta_reg;
    logic  out_valid_reg;
    logic  out_valid_next;
    meta_t out_meta_reg;
    half_t out_r_reg;
    half_t out_g_reg;
    half_t out_b_reg;
    logic  out_free;
    logic  s1_go;

    always_comb begin
        out_free    = !out_valid_reg || out_ready;
        s1_go       = s1_valid_reg && out_free;
        issue_ready = !s1_valid_reg || out_free;

        s1_valid_next = s1_valid_reg;
        if (issue) begin
            s1_valid_next = 1'b1;
        end else if (s1_go) begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_go) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_meta_reg <= meta_in;
        end
        if (s1_go) begin
            // zero the texel fields of a bad-mode item
            if (s1_meta_reg.err) begin
                out_meta_reg <= '{texel: '0, err: 1'b1, last: 1'b1};
                out_r_reg    <= '0;
                out_g_reg    <= '0;
                out_b_reg    <= '0;
            end else begin
                out_meta_reg <= s1_meta_reg;
                out_r_reg    <= finish_half(x_r);
                out_g_reg    <= finish_half(x_g);
                out_b_reg    <= finish_half(x_b);
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_meta  = out_meta_reg;
    assign out_r     = out_r_reg;
    assign out_g     = out_g_reg;
    assign out_b     = out_b_reg;

endmodule

// ===== design/bc6h_mode11_block_decoder_top.sv =====
// BC6H mode 11 block decoder; texels pass through the lane and merge registers.
// Results leave one per cycle while m_tready is high. A mode 11 block gives 16
// texels (one per issue of the single texel counter feeding the three channel
// lanes), a bad-mode block one. The next block is accepted as the last texel of
// the current one issues. Reset (aresetn low, synchronous) clears all valid
// flags and the texel counter; payload registers are not reset.
module bc6h_mode11_block_decoder_top import bc6h_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // [63:0] block_low, [127:64] block_high
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [55:0]  m_tdata,   // [3:0] texel_index, [18:4] red_half,
                                    // [33:19] green_half, [48:34] blue_half
    output logic [0:0]   m_tuser,   // [0] mode_error
    output logic         m_tlast
);

    logic        blk_valid_reg;
    logic        blk_valid_next;
    texel_t      cnt_reg;
    texel_t      cnt_next;
    logic        err_reg;
    uq_t         ep_reg [6];
    logic [63:0] idx_reg;
    logic        load;
    logic        issue;
    logic        issue_last;
    logic        issue_ready;
    logic [3:0]  tex_idx;
    logic [W_BITS-1:0] w;
    meta_t       meta_in;
    uq_t         x_r;
    uq_t         x_g;
    uq_t         x_b;
    logic        out_valid;
    meta_t       out_meta;
    half_t       out_r;
    half_t       out_g;
    half_t       out_b;

    always_comb begin
        issue      = blk_valid_reg && issue_ready;
        issue_last = err_reg || (cnt_reg == texel_t'(NUM_TEXELS - 1));
        s_tready   = !blk_valid_reg || (issue && issue_last);
        load       = s_tvalid && s_tready;

        blk_valid_next = blk_valid_reg;
        cnt_next       = cnt_reg;
        if (load) begin
            blk_valid_next = 1'b1;
            cnt_next       = '0;
        end else if (issue) begin
            if (issue_last) begin
                blk_valid_next = 1'b0;
                cnt_next       = '0;
            end else begin
                cnt_next = cnt_reg + texel_t'(1);
            end
        end

        tex_idx = idx_reg[{cnt_reg, 2'b00} +: 4];
        w       = weight_of(tex_idx);
        meta_in = '{texel: cnt_reg, err: err_reg, last: issue_last};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else begin
            blk_valid_reg <= blk_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    // Unpack and unquantize on load; texel 0 gets a 3-bit index.
    always_ff @(posedge aclk) begin
        if (load) begin
            err_reg   <= (s_tdata[4:0] != MODE11_CODE);
            ep_reg[0] <= unquantize(s_tdata[14:5]);
            ep_reg[1] <= unquantize(s_tdata[24:15]);
            ep_reg[2] <= unquantize(s_tdata[34:25]);
            ep_reg[3] <= unquantize(s_tdata[44:35]);
            ep_reg[4] <= unquantize(s_tdata[54:45]);
            ep_reg[5] <= unquantize(s_tdata[64:55]);
            idx_reg   <= {s_tdata[127:68], 1'b0, s_tdata[67:65]};
        end
    end

    bc6h_lane u_lane_r (
        .aclk  (aclk),
        .en    (issue),
        .e0    (ep_reg[0]),
        .e1    (ep_reg[3]),
        .w     (w),
        .x_reg (x_r)
    );

    bc6h_lane u_lane_g (
        .aclk  (aclk),
        .en    (issue),
        .e0    (ep_reg[1]),
        .e1    (ep_reg[4]),
        .w     (w),
        .x_reg (x_g)
    );

    bc6h_lane u_lane_b (
        .aclk  (aclk),
        .en    (issue),
        .e0    (ep_reg[2]),
        .e1    (ep_reg[5]),
        .w     (w),
        .x_reg (x_b)
    );

    bc6h_merge u_merge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .issue       (issue),
        .meta_in     (meta_in),
        .issue_ready (issue_ready),
        .x_r         (x_r),
        .x_g         (x_g),
        .x_b         (x_b),
        .out_valid   (out_valid),
        .out_ready   (m_tready),
        .out_meta    (out_meta),
        .out_r       (out_r),
        .out_g       (out_g),
        .out_b       (out_b)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {7'b0, out_b, out_g, out_r, out_meta.texel};
    assign m_tuser  = out_meta.err;
    assign m_tlast  = out_meta.last;

endmodule
